### rtl/core/scrc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sector cache tag and clock-replacement controller.
// No dependencies.
package scrc_pkg;

    localparam int NUM_SLOTS = 64;
    localparam int IDX_W     = $clog2(NUM_SLOTS);
    localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
    localparam int SECTOR_W  = 32;
    localparam int SLOT_W    = 6;
    localparam int CMD_W     = 2;

    typedef logic [IDX_W-1:0]    idx_t;
    typedef logic [CNT_W-1:0]    cnt_t;
    typedef logic [SECTOR_W-1:0] sector_t;
    typedef logic [SLOT_W-1:0]   slot_t;
    typedef logic [CMD_W-1:0]    cmd_t;

    localparam cmd_t CMD_READ  = 2'd0;
    localparam cmd_t CMD_WRITE = 2'd1;
    localparam cmd_t CMD_FLUSH = 2'd2;

    typedef struct packed {
        logic    rd_en;
        logic    we;
        idx_t    addr;
        sector_t wdata;
    } tag_req_t;

endpackage

### rtl/core/scrc_tag_ram.sv
`timescale 1ns / 1ps
// Single-port tag memory with registered read.
// Depends on scrc_pkg.
module scrc_tag_ram
(
    input  logic               clk,
    input  scrc_pkg::tag_req_t req,
    output scrc_pkg::sector_t  rdata
);

    scrc_pkg::sector_t mem [scrc_pkg::NUM_SLOTS];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.rd_en)
        begin
            rdata <= mem[req.addr];
        end
    end

endmodule

### rtl/core/sector_cache_tag_clock_replace_top.sv
`timescale 1ns / 1ps
// Sector cache tag/clock-replacement controller. Tags in scrc_tag_ram, one read per cycle.
// Depends on scrc_pkg and scrc_tag_ram.
// Search: tags are read in slot order and compared against the command's sector; a hit ends
// the search. A miss fills the next never-used slot, or once all slots are filled runs the clock
// sweep (one slot per cycle) and reads the victim tag. Results pass through ST_EMIT.
// Flush: read each slot, then emit it; NUM_SLOTS transfers. One item at a time.
// Reset clears valid count, dirty and reference bits and the pointer at once; tags are not cleared.
module sector_cache_tag_clock_replace_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // command[1:0], sector[33:2], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // hit[0], slot[6:1], fill_needed[7], writeback_needed[8],
                                   // writeback_sector[40:9], zero pad
    output logic        m_tlast
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SWEEP,
        ST_VDATA,
        ST_EMIT,
        ST_FL_RD,
        ST_FL_EMIT
    } state_t;

    localparam scrc_pkg::cnt_t FULL     = scrc_pkg::cnt_t'(scrc_pkg::NUM_SLOTS);
    localparam scrc_pkg::idx_t LAST_IDX = scrc_pkg::idx_t'(scrc_pkg::NUM_SLOTS - 1);

    function automatic scrc_pkg::idx_t ptr_inc(input scrc_pkg::idx_t p);
        ptr_inc = (p == LAST_IDX) ? '0 : p + 1'b1;
    endfunction

    state_t                       state_reg, state_next;
    scrc_pkg::cmd_t               cmd_reg, cmd_next;
    scrc_pkg::sector_t            sector_reg, sector_next;
    scrc_pkg::cnt_t               scan_reg, scan_next;
    logic                         pend_reg, pend_next;
    scrc_pkg::idx_t               pend_idx_reg, pend_idx_next;
    scrc_pkg::idx_t               victim_reg, victim_next;
    scrc_pkg::cnt_t               fill_reg, fill_next;
    scrc_pkg::idx_t               ptr_reg, ptr_next;
    logic [scrc_pkg::NUM_SLOTS-1:0] dirty_reg, dirty_next;
    logic [scrc_pkg::NUM_SLOTS-1:0] ref_reg, ref_next;
    logic                         res_hit_reg, res_hit_next;
    scrc_pkg::idx_t               res_slot_reg, res_slot_next;
    logic                         res_fill_reg, res_fill_next;
    logic                         res_wb_reg, res_wb_next;
    scrc_pkg::sector_t            res_wbsec_reg, res_wbsec_next;
    logic                         m_tvalid_reg, m_tvalid_next;
    logic                         m_hit_reg, m_hit_next;
    scrc_pkg::idx_t               m_slot_reg, m_slot_next;
    logic                         m_fill_reg, m_fill_next;
    logic                         m_wb_reg, m_wb_next;
    scrc_pkg::sector_t            m_wbsec_reg, m_wbsec_next;
    logic                         m_last_reg, m_last_next;

    scrc_pkg::tag_req_t           tag_req;
    scrc_pkg::sector_t            tag_rdata;
    logic                         out_free;
    logic                         is_write;
    logic                         fl_wb;
    scrc_pkg::idx_t               fl_idx;
    scrc_pkg::cmd_t               in_cmd;
    scrc_pkg::sector_t            in_sector;

    scrc_tag_ram u_tag_ram
    (
        .clk   (clk),
        .req   (tag_req),
        .rdata (tag_rdata)
    );

    assign in_cmd    = s_tdata[1:0];
    assign in_sector = s_tdata[33:2];
    assign out_free  = !m_tvalid_reg || m_tready;
    assign is_write  = (cmd_reg == scrc_pkg::CMD_WRITE);
    assign fl_idx    = scan_reg[scrc_pkg::IDX_W-1:0];
    assign fl_wb     = (scrc_pkg::cnt_t'(fl_idx) < fill_reg) && dirty_reg[fl_idx];

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {7'd0, m_wbsec_reg, m_wb_reg, m_fill_reg,
                       scrc_pkg::slot_t'(m_slot_reg), m_hit_reg};

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        sector_next    = sector_reg;
        scan_next      = scan_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        victim_next    = victim_reg;
        fill_next      = fill_reg;
        ptr_next       = ptr_reg;
        dirty_next     = dirty_reg;
        ref_next       = ref_reg;
        res_hit_next   = res_hit_reg;
        res_slot_next  = res_slot_reg;
        res_fill_next  = res_fill_reg;
        res_wb_next    = res_wb_reg;
        res_wbsec_next = res_wbsec_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_hit_next     = m_hit_reg;
        m_slot_next    = m_slot_reg;
        m_fill_next    = m_fill_reg;
        m_wb_next      = m_wb_reg;
        m_wbsec_next   = m_wbsec_reg;
        m_last_next    = m_last_reg;
        tag_req.rd_en  = 1'b0;
        tag_req.we     = 1'b0;
        tag_req.addr   = '0;
        tag_req.wdata  = sector_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next    = in_cmd;
                    sector_next = in_sector;
                    scan_next   = '0;
                    pend_next   = 1'b0;
                    if (in_cmd == scrc_pkg::CMD_FLUSH)
                    begin
                        state_next = ST_FL_RD;
                    end
                    else if (in_cmd == scrc_pkg::CMD_READ || in_cmd == scrc_pkg::CMD_WRITE)
                    begin
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (pend_reg && tag_rdata == sector_reg)
                begin
                    ref_next[pend_idx_reg] = 1'b1;
                    if (is_write)
                    begin
                        dirty_next[pend_idx_reg] = 1'b1;
                    end
                    res_hit_next   = 1'b1;
                    res_slot_next  = pend_idx_reg;
                    res_fill_next  = 1'b0;
                    res_wb_next    = 1'b0;
                    res_wbsec_next = '0;
                    state_next     = ST_EMIT;
                end
                else if (scan_reg < fill_reg)
                begin
                    tag_req.rd_en = 1'b1;
                    tag_req.addr  = scan_reg[scrc_pkg::IDX_W-1:0];
                    pend_next     = 1'b1;
                    pend_idx_next = scan_reg[scrc_pkg::IDX_W-1:0];
                    scan_next     = scan_reg + 1'b1;
                end
                else if (pend_reg)
                begin
                    pend_next = 1'b0;
                end
                else if (fill_reg < FULL)
                begin
                    // never-used slot: fill in order
                    tag_req.we     = 1'b1;
                    tag_req.addr   = fill_reg[scrc_pkg::IDX_W-1:0];
                    fill_next      = fill_reg + 1'b1;
                    ref_next[fill_reg[scrc_pkg::IDX_W-1:0]]   = 1'b1;
                    dirty_next[fill_reg[scrc_pkg::IDX_W-1:0]] = is_write;
                    res_hit_next   = 1'b0;
                    res_slot_next  = fill_reg[scrc_pkg::IDX_W-1:0];
                    res_fill_next  = 1'b1;
                    res_wb_next    = 1'b0;
                    res_wbsec_next = '0;
                    state_next     = ST_EMIT;
                end
                else
                begin
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                ptr_next = ptr_inc(ptr_reg);
                if (ref_reg[ptr_reg])
                begin
                    ref_next[ptr_reg] = 1'b0;
                end
                else
                begin
                    victim_next   = ptr_reg;
                    tag_req.rd_en = 1'b1;
                    tag_req.addr  = ptr_reg;
                    state_next    = ST_VDATA;
                end
            end
            ST_VDATA:
            begin
                tag_req.we               = 1'b1;
                tag_req.addr             = victim_reg;
                dirty_next[victim_reg]   = is_write;
                ref_next[victim_reg]     = 1'b1;
                res_hit_next             = 1'b0;
                res_slot_next            = victim_reg;
                res_fill_next            = 1'b1;
                res_wb_next              = dirty_reg[victim_reg];
                res_wbsec_next           = dirty_reg[victim_reg] ? tag_rdata : '0;
                state_next               = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_hit_next    = res_hit_reg;
                    m_slot_next   = res_slot_reg;
                    m_fill_next   = res_fill_reg;
                    m_wb_next     = res_wb_reg;
                    m_wbsec_next  = res_wbsec_reg;
                    m_last_next   = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_FL_RD:
            begin
                tag_req.rd_en = 1'b1;
                tag_req.addr  = fl_idx;
                state_next    = ST_FL_EMIT;
            end
            ST_FL_EMIT:
            begin
                if (out_free)
                begin
                    m_tvalid_next      = 1'b1;
                    m_hit_next         = 1'b0;
                    m_slot_next        = fl_idx;
                    m_fill_next        = 1'b0;
                    m_wb_next          = fl_wb;
                    m_wbsec_next       = fl_wb ? tag_rdata : '0;
                    m_last_next        = (fl_idx == LAST_IDX);
                    dirty_next[fl_idx] = 1'b0;
                    ref_next[fl_idx]   = 1'b1;
                    if (fl_idx == LAST_IDX)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        scan_next  = scan_reg + 1'b1;
                        state_next = ST_FL_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cmd_reg       <= scrc_pkg::CMD_READ;
            sector_reg    <= '0;
            scan_reg      <= '0;
            pend_reg      <= 1'b0;
            pend_idx_reg  <= '0;
            victim_reg    <= '0;
            fill_reg      <= '0;
            ptr_reg       <= '0;
            dirty_reg     <= '0;
            ref_reg       <= '0;
            res_hit_reg   <= 1'b0;
            res_slot_reg  <= '0;
            res_fill_reg  <= 1'b0;
            res_wb_reg    <= 1'b0;
            res_wbsec_reg <= '0;
            m_tvalid_reg  <= 1'b0;
            m_hit_reg     <= 1'b0;
            m_slot_reg    <= '0;
            m_fill_reg    <= 1'b0;
            m_wb_reg      <= 1'b0;
            m_wbsec_reg   <= '0;
            m_last_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            sector_reg    <= sector_next;
            scan_reg      <= scan_next;
            pend_reg      <= pend_next;
            pend_idx_reg  <= pend_idx_next;
            victim_reg    <= victim_next;
            fill_reg      <= fill_next;
            ptr_reg       <= ptr_next;
            dirty_reg     <= dirty_next;
            ref_reg       <= ref_next;
            res_hit_reg   <= res_hit_next;
            res_slot_reg  <= res_slot_next;
            res_fill_reg  <= res_fill_next;
            res_wb_reg    <= res_wb_next;
            res_wbsec_reg <= res_wbsec_next;
            m_tvalid_reg  <= m_tvalid_next;
            m_hit_reg     <= m_hit_next;
            m_slot_reg    <= m_slot_next;
            m_fill_reg    <= m_fill_next;
            m_wb_reg      <= m_wb_next;
            m_wbsec_reg   <= m_wbsec_next;
            m_last_reg    <= m_last_next;
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FULL)
        else $error("fill count beyond slot count");

    a_sweep_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP || state_reg == ST_VDATA) |-> fill_reg == FULL)
        else $error("clock sweep with free slots left");

    a_search_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH && pend_reg) |-> scrc_pkg::cnt_t'(pend_idx_reg) < fill_reg)
        else $error("tag compare on a never-filled slot");

    a_tag_port: assert property (@(posedge clk) disable iff (!rst_n)
        tag_req.we |-> !tag_req.rd_en)
        else $error("tag read and write in one cycle");

endmodule

### sim/scrc_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the sector cache tag controller: keeps its own copy of tags, flags and clock
// hand, predicts every result from accepted commands and compares output transfers field by field.
// Depends on scrc_pkg.
module scrc_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,   // command[1:0], sector[33:2], zero pad
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,   // hit[0], slot[6:1], fill_needed[7], writeback_needed[8],
                                   // writeback_sector[40:9], zero pad
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending
);

    typedef struct {
        bit                hit;
        scrc_pkg::slot_t   slot;
        bit                fill;
        bit                wb;
        scrc_pkg::sector_t wb_sector;
        bit                last;
    } slot_result_t;

    scrc_pkg::sector_t tag_q   [scrc_pkg::NUM_SLOTS];
    bit                valid_q [scrc_pkg::NUM_SLOTS];
    bit                dirty_q [scrc_pkg::NUM_SLOTS];
    bit                ref_q   [scrc_pkg::NUM_SLOTS];
    scrc_pkg::idx_t    hand;
    slot_result_t      expected_q [$];
    slot_result_t      want;
    int                errors;

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
        errors++;
        $display("%0t: %s mismatch, got %h expected %h", $time, what, got, exp_val);
    endtask

    task automatic cache_access(scrc_pkg::cmd_t cmd, scrc_pkg::sector_t sector);
        slot_result_t r;
        int           victim;
        int           p;
        r.hit       = 1'b0;
        r.fill      = 1'b0;
        r.wb        = 1'b0;
        r.wb_sector = '0;
        r.last      = 1'b1;
        victim      = -1;
        for (int i = 0; i < scrc_pkg::NUM_SLOTS; i++)
            if (victim < 0 && valid_q[i] && tag_q[i] == sector)
                victim = i;
        if (victim >= 0)
        begin
            r.hit = 1'b1;
            ref_q[victim] = 1'b1;
            if (cmd == scrc_pkg::CMD_WRITE)
                dirty_q[victim] = 1'b1;
        end
        else
        begin
            for (int i = 0; i < scrc_pkg::NUM_SLOTS; i++)
                if (victim < 0 && !valid_q[i])
                    victim = i;
            if (victim < 0)
            begin
                // clock sweep: clear reference bits until an unreferenced slot turns up
                p = int'(hand);
                repeat (scrc_pkg::NUM_SLOTS + 1)
                begin
                    if (victim < 0)
                    begin
                        if (ref_q[p])
                        begin
                            ref_q[p] = 1'b0;
                            p = (p + 1) % scrc_pkg::NUM_SLOTS;
                        end
                        else
                        begin
                            victim = p;
                            hand   = scrc_pkg::idx_t'((p + 1) % scrc_pkg::NUM_SLOTS);
                        end
                    end
                end
                if (dirty_q[victim])
                begin
                    r.wb        = 1'b1;
                    r.wb_sector = tag_q[victim];
                    dirty_q[victim] = 1'b0;
                end
            end
            r.fill          = 1'b1;
            valid_q[victim] = 1'b1;
            tag_q[victim]   = sector;
            ref_q[victim]   = 1'b1;
            if (cmd == scrc_pkg::CMD_WRITE)
                dirty_q[victim] = 1'b1;
        end
        r.slot = scrc_pkg::slot_t'(victim);
        expected_q.push_back(r);
    endtask

    task automatic cache_flush();
        slot_result_t r;
        for (int i = 0; i < scrc_pkg::NUM_SLOTS; i++)
        begin
            r.hit       = 1'b0;
            r.slot      = scrc_pkg::slot_t'(i);
            r.fill      = 1'b0;
            r.wb        = valid_q[i] && dirty_q[i];
            r.wb_sector = r.wb ? tag_q[i] : '0;
            r.last      = (i == scrc_pkg::NUM_SLOTS - 1);
            dirty_q[i]  = 1'b0;
            ref_q[i]    = 1'b1;
            expected_q.push_back(r);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (tag_q[i])
            begin
                tag_q[i]   = '0;
                valid_q[i] = 1'b0;
                dirty_q[i] = 1'b0;
                ref_q[i]   = 1'b0;
            end
            hand = '0;
            expected_q.delete();
            errors = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_q.size() == 0)
                    report_mismatch("unexpected transfer", m_tdata[31:0], '0);
                else
                begin
                    want = expected_q.pop_front();
                    if (m_tdata[0] !== want.hit)
                        report_mismatch("hit", 32'(m_tdata[0]), 32'(want.hit));
                    if (m_tdata[6:1] !== want.slot)
                        report_mismatch("slot", 32'(m_tdata[6:1]), 32'(want.slot));
                    if (m_tdata[7] !== want.fill)
                        report_mismatch("fill_needed", 32'(m_tdata[7]), 32'(want.fill));
                    if (m_tdata[8] !== want.wb)
                        report_mismatch("writeback_needed", 32'(m_tdata[8]), 32'(want.wb));
                    if (m_tdata[40:9] !== want.wb_sector)
                        report_mismatch("writeback_sector", m_tdata[40:9], want.wb_sector);
                    if (m_tlast !== want.last)
                        report_mismatch("last", 32'(m_tlast), 32'(want.last));
                end
            end
            if (s_tvalid && s_tready)
            begin
                case (scrc_pkg::cmd_t'(s_tdata[1:0]))
                    scrc_pkg::CMD_READ, scrc_pkg::CMD_WRITE:
                        cache_access(scrc_pkg::cmd_t'(s_tdata[1:0]), s_tdata[33:2]);
                    scrc_pkg::CMD_FLUSH:
                        cache_flush();
                    default:
                        ;
                endcase
            end
        end
        fail_count <= errors;
        pending    <= expected_q.size();
    end

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// Top-level bench for the sector cache tag controller: clock, reset, command stimulus and
// result back-pressure. Depends on scrc_pkg, scrc_checker and the block under test.
module tb;

    localparam scrc_pkg::cmd_t CMD_RESERVED = 2'd3;
    localparam int             POOL_SIZE    = 80;
    localparam int             RANDOM_ITEMS = 170;
    localparam int             LONG_HOLD    = 400;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [39:0]       s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [47:0]       m_tdata;
    logic              m_tlast;
    int                fail_count;
    int                pending;
    int                results_seen = 0;
    scrc_pkg::sector_t pool [POOL_SIZE];
    bit                burst_mode = 1'b0;

    always #5 clk = ~clk;

    sector_cache_tag_clock_replace_top uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    scrc_checker checker_i
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always @(posedge clk)
        if (m_tvalid && m_tready)
            results_seen <= results_seen + 1;

    task automatic send_command(scrc_pkg::cmd_t cmd, scrc_pkg::sector_t sector);
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, sector, cmd};
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic sender_gap();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (burst_mode || r < 60)
            n = 0;
        else if (r < 90)
            n = $urandom_range(1, 3);
        else
            n = $urandom_range(10, 40);
        if (n > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        wait (pending == 0);
    endtask

    initial
    begin
        int                counted;
        int                r;
        scrc_pkg::cmd_t    cmd;
        scrc_pkg::sector_t sector;
        rst_n = 1'b0;
        foreach (pool[i])
            pool[i] = $urandom();
        pool[0] = '0;
        pool[1] = '1;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: flush of an empty cache, extreme sectors, hits, reserved command
        send_command(scrc_pkg::CMD_FLUSH, '0);            sender_gap();
        send_command(scrc_pkg::CMD_READ, '0);             sender_gap();
        send_command(scrc_pkg::CMD_WRITE, '1);            sender_gap();
        send_command(scrc_pkg::CMD_READ, '1);             sender_gap();
        send_command(scrc_pkg::CMD_WRITE, '0);            sender_gap();
        send_command(CMD_RESERVED, 32'hA5A5A5A5);         sender_gap();
        send_command(scrc_pkg::CMD_FLUSH, '1);            sender_gap();
        send_command(scrc_pkg::CMD_WRITE, 32'h80000001);  sender_gap();
        send_command(scrc_pkg::CMD_READ, 32'h7FFFFFFE);   sender_gap();
        send_command(CMD_RESERVED, '0);                   sender_gap();
        send_command(scrc_pkg::CMD_READ, '0);             sender_gap();
        send_command(scrc_pkg::CMD_WRITE, 32'h7FFFFFFE);  sender_gap();
        send_command(scrc_pkg::CMD_FLUSH, 32'h5A5A5A5A);
        drain_results();

        counted = 0;
        for (int n = 0; counted < RANDOM_ITEMS; n++)
        begin
            if (n % 20 == 0)
                burst_mode = ($urandom_range(0, 2) == 0);
            if (n == 90)
                drain_results();
            r = $urandom_range(0, 99);
            if (r < 4)
                cmd = scrc_pkg::CMD_FLUSH;
            else if (r < 8)
                cmd = CMD_RESERVED;
            else
                cmd = ($urandom_range(0, 99) < 40) ? scrc_pkg::CMD_WRITE : scrc_pkg::CMD_READ;
            if (r < 14)
                sector = $urandom();
            else if ($urandom_range(0, 1))
                sector = pool[$urandom_range(0, POOL_SIZE / 2 - 1)];
            else
                sector = pool[$urandom_range(0, POOL_SIZE - 1)];
            send_command(cmd, sector);
            if (cmd != CMD_RESERVED)
                counted++;
            sender_gap();
        end
        @(negedge clk);
        s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (2 * scrc_pkg::NUM_SLOTS + 10) @(negedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // result back-pressure: random ready with short and long stalls, plus one long hold-off mid-run
    initial
    begin
        int pct;
        bit held;
        pct  = 100;
        held = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (!held && results_seen >= 40)
            begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            if ($urandom_range(0, 49) == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       pct = 100;
                    1:       pct = 75;
                    default: pct = 30;
                endcase
            end
            if ($urandom_range(0, 199) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(10, 40)) @(negedge clk);
            end
            m_tready <= ($urandom_range(1, 100) <= pct);
        end
    end

    initial
    begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
